// ===== src/usgp_pkg.sv =====
// Package: shared types and constants for the sphere grid point block.
`default_nettype none
package usgp_pkg;
    localparam int MAX_STEPS_DEF  = 255;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int STEP_W         = 8;
    localparam int RAD_W          = 16;
    localparam int CFG_W          = 16;
    localparam int IDX_W          = 2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_VCOUNT  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // Odd Taylor coefficients of sin(pi/2*x), unsigned Q30.
    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598668;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026995;
    localparam logic [31:0] C9 = 32'd172272;

    typedef struct packed {
        logic [7:0] ring;
        logic [7:0] segment;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               quad_valid;
        logic [15:0]        first_index;
        logic [15:0]        second_index;
        logic [1:0]         status;
    } t_out;
endpackage
`default_nettype wire

// ===== src/uv_sphere_grid_point.sv =====
// Top level: UV sphere grid point generator.
//   channel | dir | signals
//   in      | in  | i_in_valid, o_in_ready, i_in (ring, segment)
//   out     | out | o_out_valid, i_out_ready, o_out (normal, position, texture, quad, status)
//   cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// Each item passes NW+10 register stages, NW = max(ANGLE_BITS, 16) + 11: input 1, divider
// row NW, sine 7, product 1, output 1. One item per cycle while the chain advances; all
// units form a shift chain advanced as a whole. The chain advances while the output
// register is empty or taken, so a stall on the output freezes every stage. Reset clears
// valid bits and the registers to defaults.
`default_nettype none
module uv_sphere_grid_point import usgp_pkg::*; #(
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    localparam int NW  = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 11;
    localparam int DLW = NW;
    localparam int SLW = 7;
    localparam int PIPE = 1 + DLW + SLW + 1;

    logic [STEP_W-1:0] r_w_cfg, r_h_cfg;
    logic [RAD_W-1:0]  r_rad;
    logic              w_adv;
    logic [PIPE-1:0]   r_vld;
    t_out              r_out;
    logic              r_out_v;

    // Every stage of the chain, the divider and sine rows included, loads only on w_adv,
    // so a stall at the output holds each item in place.
    assign w_adv = !r_out_v || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cfg <= STEP_W'(16);
            r_h_cfg <= STEP_W'(16);
            r_rad   <= RAD_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_w_cfg <= i_cfg_data[STEP_W-1:0];
                REG_HEIGHT: r_h_cfg <= i_cfg_data[STEP_W-1:0];
                REG_RADIUS: r_rad   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [STEP_W-1:0] w_w, w_h;
    assign w_w = (r_w_cfg > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : r_w_cfg;
    assign w_h = (r_h_cfg > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : r_h_cfg;

    // Stage 0: register input and decode.
    typedef struct packed {
        logic        outside;
        logic        quad;
        logic [15:0] first;
        logic [15:0] second;
        logic        vcount;
    } t_side;

    t_in   r_in;
    t_side r_sd0;
    logic [7:0] r_w0, r_h0;
    logic [15:0] r_rad0;
    t_side w_sd;
    logic [16:0] w_first;
    logic [17:0] w_vc;

    always_comb begin
        w_first = 17'(i_in.ring) * 17'({1'b0, w_h} + 9'd1) + 17'(i_in.segment);
        w_vc = 18'({1'b0, w_w} + 9'd1) * 18'({1'b0, w_h} + 9'd1);
        w_sd.outside = (w_w == '0) || (w_h == '0) || (i_in.ring > w_w) || (i_in.segment > w_h);
        w_sd.quad = (i_in.ring < w_w) && (i_in.segment < w_h);
        w_sd.first = w_sd.quad ? w_first[15:0] : '0;
        w_sd.second = w_sd.quad ? 16'(w_first + 17'(w_h) + 17'd1) : '0;
        w_sd.vcount = w_vc > 18'd65535;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in   <= i_in;
            r_sd0  <= w_sd;
            r_w0   <= w_w;
            r_h0   <= w_h;
            r_rad0 <= r_rad;
        end
    end

    // Divider numerators; when outside, the denominator may be zero but result is discarded.
    logic [NW-1:0] w_nt, w_np, w_nu, w_nv;
    logic [8:0]    w_dt, w_dp, w_du, w_dv;
    always_comb begin
        w_nt = NW'({r_in.ring, {ANGLE_BITS{1'b0}}}) + NW'(r_w0);
        w_dt = {r_w0, 1'b0};
        w_np = NW'({r_in.segment, {ANGLE_BITS{1'b0}}}) + NW'(r_h0[7:1]);
        w_dp = {1'b0, r_h0};
        w_nu = NW'({r_in.segment, 16'd0}) + NW'(r_h0[7:1]);
        w_du = {1'b0, r_h0};
        w_nv = NW'({r_in.ring, 16'd0}) + NW'(r_w0[7:1]);
        w_dv = {1'b0, r_w0};
    end

    logic [NW-1:0] w_qt, w_qp, w_qu, w_qv;
    usgp_divider #(.NW(NW)) u_dt (.i_clk(i_clk), .i_en(w_adv), .i_num(w_nt), .i_den(w_dt),
                                  .o_quo(w_qt));
    usgp_divider #(.NW(NW)) u_dp (.i_clk(i_clk), .i_en(w_adv), .i_num(w_np), .i_den(w_dp),
                                  .o_quo(w_qp));
    usgp_divider #(.NW(NW)) u_du (.i_clk(i_clk), .i_en(w_adv), .i_num(w_nu), .i_den(w_du),
                                  .o_quo(w_qu));
    usgp_divider #(.NW(NW)) u_dv (.i_clk(i_clk), .i_en(w_adv), .i_num(w_nv), .i_den(w_dv),
                                  .o_quo(w_qv));

    // Side data delayed alongside the dividers and sines.
    localparam int SDL = DLW + SLW;
    t_side       r_sdd [SDL];
    logic [15:0] r_radd [SDL];
    logic [16:0] r_tu [SLW];
    logic [16:0] r_tv [SLW];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sdd[0]  <= r_sd0;
            r_radd[0] <= r_rad0;
            for (int k = 1; k < SDL; k++) begin
                r_sdd[k]  <= r_sdd[k-1];
                r_radd[k] <= r_radd[k-1];
            end
            r_tu[0] <= 17'd65536 - w_qu[16:0];
            r_tv[0] <= 17'd65536 - w_qv[16:0];
            for (int k = 1; k < SLW; k++) begin
                r_tu[k] <= r_tu[k-1];
                r_tv[k] <= r_tv[k-1];
            end
        end
    end

    localparam logic [ANGLE_BITS-1:0] QA = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    logic signed [15:0] w_st, w_ct, w_sp, w_cp;
    usgp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_st (.i_clk(i_clk), .i_en(w_adv),
        .i_angle(w_qt[ANGLE_BITS-1:0]), .o_sine(w_st));
    usgp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_ct (.i_clk(i_clk), .i_en(w_adv),
        .i_angle(w_qt[ANGLE_BITS-1:0] + QA), .o_sine(w_ct));
    usgp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sp (.i_clk(i_clk), .i_en(w_adv),
        .i_angle(w_qp[ANGLE_BITS-1:0]), .o_sine(w_sp));
    usgp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cp (.i_clk(i_clk), .i_en(w_adv),
        .i_angle(w_qp[ANGLE_BITS-1:0] + QA), .o_sine(w_cp));

    // Normal products, rounded to nearest with halves rounded up toward positive infinity.
    logic signed [31:0] w_px, w_pz;
    logic signed [15:0] r_nx, r_ny, r_nz;
    t_side       r_sd1;
    logic [15:0] r_rad1;
    logic [16:0] r_tu1, r_tv1;
    function automatic logic signed [15:0] rnd(input logic signed [31:0] p);
        logic [31:0] a;
        logic [31:0] m;
        begin
            a = p[31] ? 32'(-p) : 32'(p);
            m = p[31] ? ((a + 32'd16383) >> 15) : ((a + 32'd16384) >> 15);
            rnd = p[31] ? -$signed(m[15:0]) : $signed(m[15:0]);
        end
    endfunction
    assign w_px = w_cp * w_st;
    assign w_pz = w_sp * w_st;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nx   <= rnd(w_px);
            r_nz   <= rnd(w_pz);
            r_ny   <= w_ct;
            r_sd1  <= r_sdd[SDL-1];
            r_rad1 <= r_radd[SDL-1];
            r_tu1  <= r_tu[SLW-1];
            r_tv1  <= r_tv[SLW-1];
        end
    end

    t_out w_o;
    always_comb begin
        w_o = '0;
        if (r_sd1.outside) begin
            w_o.status = ST_OUTSIDE;
        end else begin
            w_o.normal_x = r_nx;
            w_o.normal_y = r_ny;
            w_o.normal_z = r_nz;
            w_o.pos_x = $signed({1'b0, r_rad1}) * r_nx;
            w_o.pos_y = $signed({1'b0, r_rad1}) * r_ny;
            w_o.pos_z = $signed({1'b0, r_rad1}) * r_nz;
            w_o.tex_u = r_tu1;
            w_o.tex_v = r_tv1;
            w_o.quad_valid = r_sd1.quad;
            w_o.first_index = r_sd1.first;
            w_o.second_index = r_sd1.second;
            w_o.status = r_sd1.vcount ? ST_VCOUNT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_vld   <= {r_vld[PIPE-2:0], i_in_valid};
            r_out_v <= r_vld[PIPE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_out <= w_o;
    end

    assign o_out_valid = r_out_v;
    assign o_out = r_out;
endmodule
`default_nettype wire

// ===== src/usgp_div_cell.sv =====
// Restoring divider cell: one quotient bit per cell, handing the partial remainder down the row.
`default_nettype none
module usgp_div_cell import usgp_pkg::*; #(
    parameter int NW = 26,
    parameter int DW = 9,
    parameter int QW = 26,
    parameter int BIT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW:0]   i_rem,
    input  wire logic [QW-1:0] i_quo,
    output logic      [NW-1:0] o_num,
    output logic      [DW-1:0] o_den,
    output logic      [DW:0]   o_rem,
    output logic      [QW-1:0] o_quo
);
    logic [DW+1:0] w_trial;
    logic [DW+1:0] w_diff;
    logic [DW:0]   n_rem;
    logic [QW-1:0] n_quo;

    always_comb begin
        w_trial = {i_rem, i_num[BIT]};
        w_diff  = w_trial - {2'b00, i_den};
        n_quo   = i_quo;
        if (!w_diff[DW+1]) begin
            n_rem      = w_diff[DW:0];
            n_quo[BIT] = 1'b1;
        end else begin
            n_rem      = w_trial[DW:0];
            n_quo[BIT] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= i_num;
            o_den <= i_den;
            o_rem <= n_rem;
            o_quo <= n_quo;
        end
    end
endmodule
`default_nettype wire

// ===== src/usgp_divider.sv =====
// Pipelined divider built as a row of restoring cells, one quotient bit per cell.
`default_nettype none
module usgp_divider import usgp_pkg::*; #(
    parameter int NW = 26,
    parameter int DW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [NW-1:0] o_quo
);
    logic [NW-1:0] w_num [NW+1];
    logic [DW-1:0] w_den [NW+1];
    logic [DW:0]   w_rem [NW+1];
    logic [NW-1:0] w_quo [NW+1];

    assign w_num[0] = i_num;
    assign w_den[0] = i_den;
    assign w_rem[0] = '0;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        usgp_div_cell #(.NW(NW), .DW(DW), .QW(NW), .BIT(NW-1-g)) u_cell (
            .i_clk (i_clk), .i_en (i_en),
            .i_num (w_num[g]), .i_den (w_den[g]), .i_rem (w_rem[g]), .i_quo (w_quo[g]),
            .o_num (w_num[g+1]), .o_den (w_den[g+1]), .o_rem (w_rem[g+1]),
            .o_quo (w_quo[g+1])
        );
    end

    assign o_quo = w_quo[NW];
endmodule
`default_nettype wire

// ===== src/usgp_sine.sv =====
// Pipelined Q1.15 sine of an angle given as a fraction of a turn.
`default_nettype none
module usgp_sine import usgp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [15:0]         o_sine
);
    localparam int LAT = 7;
    localparam logic [ANGLE_BITS-1:0] QUART = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic [1:0]  r_q [LAT];
    logic [31:0] r_x [6];
    logic [31:0] r_x2 [1:4];
    logic [31:0] r_s [1:6];
    logic [15:0] w_m;

    logic [ANGLE_BITS-1:0] w_r;
    logic [63:0]           w_xx;
    logic [63:0]           w_p [4];
    logic [63:0]           w_fin;
    logic [47:0]           w_x;

    always_comb begin
        w_r = {2'b00, i_angle[ANGLE_BITS-3:0]};
        if (i_angle[ANGLE_BITS-2]) w_r = QUART - w_r;
        w_x = 48'(w_r) << (32 - ANGLE_BITS);
        w_xx = 64'(r_x[0]) * 64'(r_x[0]);
        for (int k = 0; k < 4; k++) w_p[k] = 64'(r_s[k+1]) * 64'(r_x2[k+1]);
        w_fin = 64'(r_s[5]) * 64'(r_x[5]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]  <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            r_x[0]  <= w_x[31:0];
            for (int k = 1; k < LAT; k++) begin
                r_q[k] <= r_q[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                r_x[k] <= r_x[k-1];
            end
            r_x2[1] <= w_xx[61:30];
            for (int k = 2; k < 5; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_s[1]  <= C9;
            r_s[2]  <= C7 - w_p[0][61:30];
            r_s[3]  <= C5 - w_p[1][61:30];
            r_s[4]  <= C3 - w_p[2][61:30];
            r_s[5]  <= C1 - w_p[3][61:30];
            r_s[6]  <= w_fin[61:30];
        end
    end

    always_comb begin
        logic [32:0] v;
        v = (33'(r_s[6]) + 33'd16384) >> 15;
        w_m = (v > 33'd32767) ? 16'd32767 : v[15:0];
        o_sine = r_q[LAT-1][1] ? -$signed(w_m) : $signed(w_m);
    end
endmodule
`default_nettype wire

// ===== verif/uv_sphere_grid_point_tb.sv =====
// Testbench for the UV sphere grid point block: directed and randomized stream checked against a predictor.
`timescale 1ns / 1ps
module uv_sphere_grid_point_tb import usgp_pkg::*;;

    localparam int ANGLE_BITS = ANGLE_BITS_DEF;
    localparam longint TURN = 64'd1 << ANGLE_BITS;
    localparam longint QUARTER = 64'd1 << (ANGLE_BITS - 2);
    localparam int LATENCY = 1 + ANGLE_BITS + 11 + 7 + 2 + 1;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in        i_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out;
    logic       i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    uv_sphere_grid_point uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies used by the predictor.
    logic [7:0]  width_steps = 8'd16;
    logic [7:0]  height_steps = 8'd16;
    logic [15:0] sphere_radius = 16'd256;

    t_out expected_points[$];
    int   mismatches = 0;
    int   points_checked = 0;
    int   hold_off = 0;
    int   rx_gap = 0;
    bit   random_stall = 1'b1;

    function automatic longint quarter_sine(longint r);
        longint x, x2, s;
        x = r << (32 - ANGLE_BITS);
        x2 = (x * x) >>> 30;
        s = C9;
        s = longint'(C7) - ((s * x2) >>> 30);
        s = longint'(C5) - ((s * x2) >>> 30);
        s = longint'(C3) - ((s * x2) >>> 30);
        s = longint'(C1) - ((s * x2) >>> 30);
        return (s * x) >>> 30;
    endfunction

    function automatic longint sine_q15(longint a);
        longint q, r, m;
        a = a & (TURN - 1);
        q = a >> (ANGLE_BITS - 2);
        r = a & (QUARTER - 1);
        if (q[0]) r = QUARTER - r;
        m = (quarter_sine(r) + 16384) >> 15;
        if (m > 32767) m = 32767;
        return q[1] ? -m : m;
    endfunction

    function automatic longint round_q15(longint p);
        return p >= 0 ? (p + 16384) / 32768 : -((-p + 16383) / 32768);
    endfunction

    function automatic t_out grid_point(t_in pt);
        t_out res;
        longint w, h, ring, seg, ta, pa, st, ct, sp, cp, nx, ny, nz, first;
        res = '0;
        w = width_steps;
        h = height_steps;
        ring = pt.ring;
        seg = pt.segment;
        if (w == 0 || h == 0 || ring > w || seg > h) begin
            res.status = ST_OUTSIDE;
            return res;
        end
        ta = ((ring << ANGLE_BITS) + w) / (2 * w);
        pa = (((seg << ANGLE_BITS) + h / 2) / h) & (TURN - 1);
        st = sine_q15(ta);
        ct = sine_q15(ta + QUARTER);
        sp = sine_q15(pa);
        cp = sine_q15(pa + QUARTER);
        nx = round_q15(cp * st);
        ny = ct;
        nz = round_q15(sp * st);
        res.normal_x = nx[15:0];
        res.normal_y = ny[15:0];
        res.normal_z = nz[15:0];
        res.pos_x = 32'(longint'(sphere_radius) * nx);
        res.pos_y = 32'(longint'(sphere_radius) * ny);
        res.pos_z = 32'(longint'(sphere_radius) * nz);
        res.tex_u = 17'(65536 - ((seg * 65536 + h / 2) / h));
        res.tex_v = 17'(65536 - ((ring * 65536 + w / 2) / w));
        if (ring < w && seg < h) begin
            first = ring * (h + 1) + seg;
            res.quad_valid = 1'b1;
            res.first_index = first[15:0];
            res.second_index = 16'(first + h + 1);
        end
        res.status = ((w + 1) * (h + 1) > 65535) ? ST_VCOUNT : ST_OK;
        return res;
    endfunction

    task automatic send_point(input logic [7:0] ring, input logic [7:0] segment);
        int gap;
        t_in pt;
        gap = random_stall ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pt.ring = ring;
        pt.segment = segment;
        i_in <= pt;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_points.push_back(grid_point(pt));
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  width_steps = value[7:0];
            REG_HEIGHT: height_steps = value[7:0];
            REG_RADIUS: sphere_radius = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int w, input int h, input int rad);
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_RADIUS, CFG_W'(rad));
    endtask

    // Receiver: waits a drawn number of cycles before each item, plus a long hold-off
    // when requested.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_gap = random_stall ? int'($urandom_range(0, 5)) : 0;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", o_out);
            end else begin
                t_out exp_pt;
                exp_pt = expected_points.pop_front();
                points_checked++;
                if (o_out !== exp_pt) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("item %0d differs", points_checked);
                        $display("  expected %p", exp_pt);
                        $display("  actual   %p", o_out);
                    end
                end
            end
        end
    end

    task automatic test_reset_grid();
        // Corners of the default 16x16 grid, an interior point and outside points.
        send_point(0, 0);
        send_point(16, 16);
        send_point(16, 0);
        send_point(0, 16);
        send_point(8, 4);
        send_point(17, 3);
        send_point(3, 17);
        send_point(255, 255);
    endtask

    task automatic test_extremes();
        set_grid(255, 255, 65535);  // vertex count overflow
        send_point(255, 255);
        send_point(0, 0);
        send_point(254, 254);
        send_point(128, 64);
        set_grid(0, 5, 0);          // zero step count: all outside
        send_point(0, 0);
        send_point(1, 1);
        set_grid(1, 1, 1);
        send_point(0, 0);
        send_point(1, 1);
        send_point(1, 0);
        send_point(2, 0);
        set_grid(3, 0, 32768);
        send_point(0, 0);
        set_grid(200, 255, 12345);
        send_point(199, 254);
        send_point(100, 170);
    endtask

    task automatic random_phase(input int count, input int w, input int h, input int rad);
        set_grid(w, h, rad);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0)
                send_point(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                send_point(8'($urandom_range(0, w)), 8'($urandom_range(0, h)));
        end
    endtask

    task automatic test_random();
        random_phase(250, 16, 16, 256);
        random_phase(250, $urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 65535));
        random_phase(200, $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 65535));
        random_phase(200, 255, 255, 65535);
        random_phase(200, $urandom_range(100, 255), $urandom_range(200, 255),
                     $urandom_range(0, 65535));
        random_phase(150, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 65535));
    endtask

    task automatic test_back_pressure();
        random_phase(0, 40, 37, 700);
        random_stall = 1'b0;
        hold_off = 200;
        repeat (80) send_point(8'($urandom_range(0, 40)), 8'($urandom_range(0, 37)));
        random_stall = 1'b1;
    endtask

    initial begin
        int spin;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_grid();
        test_extremes();
        test_back_pressure();
        test_random();
        i_in_valid <= 1'b0;
        spin = 0;
        while (expected_points.size() != 0 && spin < 100000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Covered default, degenerate, overflowing and random grids with random radii,");
        $display("%0d items checked under random and long output stalls.", points_checked);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("uv_sphere_grid_point: match");
        else
            $display("uv_sphere_grid_point: mismatch");
        $finish;
    end

    initial begin
        #5ms;
        $display("uv_sphere_grid_point: mismatch");
        $finish;
    end
endmodule
